/* hdl/assert_macros.svh */
// assertion macros shared by the rsa core
// no dependencies; clock and active-low reset are passed in
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, held off during reset
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hdl/rsa_pkg.sv */
// shared types, constants and width helpers for the rsa core
// used by every module of the block; no dependencies
`timescale 1ns / 1ps

package rsa_pkg;

  localparam int MSG_W        = 62;
  localparam int CFG_W        = 31;
  localparam int CFG_IDX_W    = 1;
  localparam int PRIME_BITS_D = 31;
  localparam int P_RESET      = 61;
  localparam int Q_RESET      = 53;

  // register indexes of the config port
  localparam logic [CFG_IDX_W-1:0] REG_PRIME_P = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PRIME_Q = 1'b1;

  // request kinds
  localparam logic REQ_ENCRYPT = 1'b0;
  localparam logic REQ_DECRYPT = 1'b1;

  // datapath width: room for n and for the raw message
  function automatic int data_width(input int pb);
    return (2 * pb > MSG_W) ? 2 * pb : MSG_W;
  endfunction

  // datapath micro operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_PHI,
    OP_GCD_INIT,
    OP_GCD_DIV,
    OP_GCD_STEP,
    OP_E_INC,
    OP_INV_INIT,
    OP_INV_DIV,
    OP_INV_MUL,
    OP_INV_UPD,
    OP_D_SET,
    OP_POW_INIT,
    OP_POW_BASE,
    OP_POW_MACC,
    OP_POW_WACC,
    OP_POW_SQ,
    OP_POW_WSQ,
    OP_FINISH
  } op_t;

  // datapath status back to the controller
  typedef struct packed {
    logic div_busy;
    logic mm_busy;
    logic n_zero;
    logic e_lt_phi;
    logic ga_zero;
    logic gb_one;
    logic phi_ge2;
    logic inv_go;
    logic ex_zero;
    logic ex_lsb;
  } status_t;

endpackage

/* hdl/rsa_textbook_crypt_core.sv */
// Textbook rsa encrypt/decrypt core: one item per start, one result strobe per item.
// Each item derives n, phi, e and d from the configured primes, then raises the
// message to e or d mod n. One item runs at a time; busy stays high until the
// result strobe, which the receiver cannot stall. Run time is set by one shared
// restoring divider and one add-and-double modular multiplier, which serve the gcd
// steps of the exponent search, the euclid steps and each exponent bit; keys of the
// reset primes' scale take far less time than a full-width decrypt with key setup.
// Config writes take effect at once and belong to idle periods.
// depends on rsa_pkg, rsa_ctrl, rsa_dp and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rsa_textbook_crypt_core #(
  parameter int PRIME_BITS = rsa_pkg::PRIME_BITS_D
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rsa_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [rsa_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_req_type,
  input  logic [rsa_pkg::MSG_W-1:0]     in_message,
  output logic                          out_valid,
  output logic [rsa_pkg::MSG_W-1:0]     out_result
);

  rsa_pkg::op_t     op;
  rsa_pkg::status_t status;

  // controller
  rsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .status    (status),
    .op        (op),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // datapath
  rsa_dp #(.PRIME_BITS(PRIME_BITS)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .in_req_type (in_req_type),
    .in_message  (in_message),
    .op          (op),
    .status      (status),
    .out_result  (out_result)
  );

  // result strobe only while an item is in work, one cycle wide, then idle
  `ASSERT_IMP(a_valid_busy, clk, rst_n, out_valid, busy)
  `ASSERT_NXT(a_valid_pulse, clk, rst_n, out_valid, !out_valid && !busy)
  `ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)

endmodule

/* hdl/rsa_div.sv */
// restoring divider, one quotient bit per cycle
// depends on rsa_pkg for the datapath width
`timescale 1ns / 1ps

module rsa_div #(
  parameter int PRIME_BITS = rsa_pkg::PRIME_BITS_D
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       start,
  input  logic [rsa_pkg::data_width(PRIME_BITS)-1:0] num,
  input  logic [rsa_pkg::data_width(PRIME_BITS)-1:0] den,
  output logic                                       busy,
  output logic [rsa_pkg::data_width(PRIME_BITS)-1:0] quo,
  output logic [rsa_pkg::data_width(PRIME_BITS)-1:0] rem
);

  localparam int DW = rsa_pkg::data_width(PRIME_BITS);
  localparam int CW = $clog2(DW + 1);

  logic          busy_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] qn_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [DW:0]   sh;
  logic [DW:0]   diff;
  logic          fits;

  // shift in the next numerator bit and try the subtract
  always_comb begin
    sh   = {rem_r, qn_r[DW-1]};
    diff = sh - {1'b0, den_r};
    fits = (sh >= {1'b0, den_r});
  end

  // busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == '0) begin
      busy_r <= 1'b0;
    end
  end

  // quotient and remainder registers
  always_ff @(posedge clk) begin
    if (start) begin
      qn_r  <= num;
      den_r <= den;
      rem_r <= '0;
      cnt_r <= CW'(DW);
    end else if (busy_r && cnt_r != '0) begin
      rem_r <= fits ? diff[DW-1:0] : sh[DW-1:0];
      qn_r  <= {qn_r[DW-2:0], fits};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign busy = busy_r;
  assign quo  = qn_r;
  assign rem  = rem_r;

endmodule

/* hdl/rsa_mmul.sv */
// modular multiplier, add and double over one multiplier bit per cycle
// depends on rsa_pkg for the datapath width
`timescale 1ns / 1ps

module rsa_mmul #(
  parameter int PRIME_BITS = rsa_pkg::PRIME_BITS_D
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       start,
  input  logic [rsa_pkg::data_width(PRIME_BITS)-1:0] a,
  input  logic [rsa_pkg::data_width(PRIME_BITS)-1:0] b,
  input  logic [rsa_pkg::data_width(PRIME_BITS)-1:0] m,
  output logic                                       busy,
  output logic [rsa_pkg::data_width(PRIME_BITS)-1:0] res
);

  localparam int DW = rsa_pkg::data_width(PRIME_BITS);

  logic          busy_r;
  logic [DW-1:0] a_r;
  logic [DW-1:0] b_r;
  logic [DW-1:0] m_r;
  logic [DW-1:0] acc_r;

  // (x + y) mod md for x, y below md
  function automatic logic [DW-1:0] add_mod(input logic [DW-1:0] x,
                                            input logic [DW-1:0] y,
                                            input logic [DW-1:0] md);
    logic [DW:0] s;
    logic [DW:0] t;
    s = {1'b0, x} + {1'b0, y};
    t = s - {1'b0, md};
    return (s >= {1'b0, md}) ? t[DW-1:0] : s[DW-1:0];
  endfunction

  // busy until the multiplier runs out of set bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && b_r == '0) begin
      busy_r <= 1'b0;
    end
  end

  // accumulate and double
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      m_r   <= m;
      acc_r <= '0;
    end else if (busy_r && b_r != '0) begin
      if (b_r[0]) begin
        acc_r <= add_mod(acc_r, a_r, m_r);
      end
      a_r <= add_mod(a_r, a_r, m_r);
      b_r <= b_r >> 1;
    end
  end

  assign busy = busy_r;
  assign res  = acc_r;

endmodule

/* hdl/rsa_dp.sv */
// rsa datapath: config primes, key setup registers, exponent registers
// depends on rsa_pkg, rsa_div and rsa_mmul
`timescale 1ns / 1ps

module rsa_dp #(
  parameter int PRIME_BITS = rsa_pkg::PRIME_BITS_D
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rsa_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [rsa_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_req_type,
  input  logic [rsa_pkg::MSG_W-1:0]     in_message,
  input  rsa_pkg::op_t                  op,
  output rsa_pkg::status_t              status,
  output logic [rsa_pkg::MSG_W-1:0]     out_result
);

  localparam int DW = rsa_pkg::data_width(PRIME_BITS);
  localparam int PW = 2 * PRIME_BITS;

  logic [PRIME_BITS-1:0] p_r;
  logic [PRIME_BITS-1:0] q_r;
  logic [PRIME_BITS-1:0] pm1;
  logic [PRIME_BITS-1:0] qm1;
  logic [PW-1:0]         mul_a;
  logic [PW-1:0]         mul_b;
  logic [PW-1:0]         prod;

  logic                  kind_r;
  logic [DW-1:0]         msg_r;
  logic [DW-1:0]         n_r;
  logic [DW-1:0]         phi_r;
  logic [DW-1:0]         e_r;
  logic [DW-1:0]         d_r;
  logic [DW-1:0]         ga_r;
  logic [DW-1:0]         gb_r;
  logic [DW-1:0]         r0_r;
  logic [DW-1:0]         r1_r;
  logic [DW-1:0]         x_r;
  logic [DW-1:0]         y_r;
  logic [DW-1:0]         ny;
  logic [DW-1:0]         acc_r;
  logic [DW-1:0]         base_r;
  logic [DW-1:0]         ex_r;
  logic [rsa_pkg::MSG_W-1:0] res_r;

  logic                  div_start;
  logic [DW-1:0]         div_num;
  logic [DW-1:0]         div_den;
  logic                  div_busy;
  logic [DW-1:0]         div_quo;
  logic [DW-1:0]         div_rem;

  logic                  mm_start;
  logic [DW-1:0]         mm_a;
  logic [DW-1:0]         mm_b;
  logic [DW-1:0]         mm_m;
  logic                  mm_busy;
  logic [DW-1:0]         mm_res;

  // config registers, masked to the prime width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r <= PRIME_BITS'(rsa_pkg::P_RESET);
      q_r <= PRIME_BITS'(rsa_pkg::Q_RESET);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        rsa_pkg::REG_PRIME_P: p_r <= PRIME_BITS'(cfg_wdata);
        rsa_pkg::REG_PRIME_Q: q_r <= PRIME_BITS'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // one shared multiplier for n and phi
  always_comb begin
    pm1   = (p_r != '0) ? p_r - 1'b1 : '0;
    qm1   = (q_r != '0) ? q_r - 1'b1 : '0;
    mul_a = (op == rsa_pkg::OP_PHI) ? PW'(pm1) : PW'(p_r);
    mul_b = (op == rsa_pkg::OP_PHI) ? PW'(qm1) : PW'(q_r);
    prod  = mul_a * mul_b;
  end

  // new euclid coefficient: x - q*y mod phi
  assign ny = (x_r >= mm_res) ? (x_r - mm_res) : (x_r + (phi_r - mm_res));

  // divider operand select
  always_comb begin
    div_start = 1'b0;
    div_num   = gb_r;
    div_den   = ga_r;
    unique case (op)
      rsa_pkg::OP_GCD_DIV: div_start = 1'b1;
      rsa_pkg::OP_INV_DIV: begin
        div_start = 1'b1;
        div_num   = r0_r;
        div_den   = r1_r;
      end
      rsa_pkg::OP_POW_INIT: begin
        div_start = 1'b1;
        div_num   = msg_r;
        div_den   = n_r;
      end
      default: ;
    endcase
  end

  // modular multiplier operand select
  always_comb begin
    mm_start = 1'b0;
    mm_a     = base_r;
    mm_b     = base_r;
    mm_m     = n_r;
    unique case (op)
      rsa_pkg::OP_INV_MUL: begin
        mm_start = 1'b1;
        mm_a     = div_quo;
        mm_b     = y_r;
        mm_m     = phi_r;
      end
      rsa_pkg::OP_POW_MACC: begin
        mm_start = 1'b1;
        mm_a     = acc_r;
      end
      rsa_pkg::OP_POW_SQ: mm_start = 1'b1;
      default: ;
    endcase
  end

  rsa_div #(.PRIME_BITS(PRIME_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  rsa_mmul #(.PRIME_BITS(PRIME_BITS)) u_mmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mm_start),
    .a     (mm_a),
    .b     (mm_b),
    .m     (mm_m),
    .busy  (mm_busy),
    .res   (mm_res)
  );

  // working registers, one micro operation per cycle
  always_ff @(posedge clk) begin
    unique case (op)
      rsa_pkg::OP_LOAD: begin
        kind_r <= in_req_type;
        msg_r  <= DW'(in_message);
        n_r    <= DW'(prod);
        e_r    <= DW'(2);
        d_r    <= '0;
      end
      rsa_pkg::OP_PHI:      phi_r <= DW'(prod);
      rsa_pkg::OP_GCD_INIT: begin
        ga_r <= e_r;
        gb_r <= phi_r;
      end
      rsa_pkg::OP_GCD_STEP: begin
        gb_r <= ga_r;
        ga_r <= div_rem;
      end
      rsa_pkg::OP_E_INC:    e_r <= e_r + 1'b1;
      rsa_pkg::OP_INV_INIT: begin
        r0_r <= e_r;
        r1_r <= phi_r;
        x_r  <= DW'(1);
        y_r  <= '0;
      end
      rsa_pkg::OP_INV_UPD: begin
        r0_r <= r1_r;
        r1_r <= div_rem;
        x_r  <= y_r;
        y_r  <= ny;
      end
      rsa_pkg::OP_D_SET:    d_r <= x_r;
      rsa_pkg::OP_POW_INIT: begin
        acc_r <= DW'(1);
        ex_r  <= (kind_r == rsa_pkg::REQ_ENCRYPT) ? e_r : d_r;
      end
      rsa_pkg::OP_POW_BASE: base_r <= div_rem;
      rsa_pkg::OP_POW_WACC: acc_r <= mm_res;
      rsa_pkg::OP_POW_WSQ: begin
        base_r <= mm_res;
        ex_r   <= ex_r >> 1;
      end
      rsa_pkg::OP_FINISH:
        res_r <= (n_r == '0) ? '0 : acc_r[rsa_pkg::MSG_W-1:0];
      default: ;
    endcase
  end

  // status flags for the controller
  always_comb begin
    status.div_busy = div_busy;
    status.mm_busy  = mm_busy;
    status.n_zero   = (n_r == '0);
    status.e_lt_phi = (e_r < phi_r);
    status.ga_zero  = (ga_r == '0);
    status.gb_one   = (gb_r == DW'(1));
    status.phi_ge2  = (phi_r >= DW'(2));
    status.inv_go   = (r0_r > DW'(1)) && (r1_r != '0);
    status.ex_zero  = (ex_r == '0);
    status.ex_lsb   = ex_r[0];
  end

  assign out_result = res_r;

endmodule

/* hdl/rsa_ctrl.sv */
// rsa controller: sequences key setup, inverse and exponentiation
// depends on rsa_pkg for op codes and the status struct
`timescale 1ns / 1ps

module rsa_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  rsa_pkg::status_t status,
  output rsa_pkg::op_t     op,
  output logic             busy,
  output logic             out_valid
);

  typedef enum logic [16:0] {
    ST_IDLE  = 17'h00001,
    ST_PHI   = 17'h00002,
    ST_ECHK  = 17'h00004,
    ST_GCHK  = 17'h00008,
    ST_GWAIT = 17'h00010,
    ST_DINIT = 17'h00020,
    ST_ICHK  = 17'h00040,
    ST_IDIV  = 17'h00080,
    ST_IMUL  = 17'h00100,
    ST_PINIT = 17'h00200,
    ST_PBASE = 17'h00400,
    ST_PCHK  = 17'h00800,
    ST_PACC  = 17'h01000,
    ST_PSQS  = 17'h02000,
    ST_PSQ   = 17'h04000,
    ST_FIN   = 17'h08000,
    ST_DONE  = 17'h10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // next state and micro operation
  always_comb begin
    state_nxt = state_r;
    op        = rsa_pkg::OP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          op        = rsa_pkg::OP_LOAD;
          state_nxt = ST_PHI;
        end
      end
      ST_PHI: begin
        op        = rsa_pkg::OP_PHI;
        state_nxt = ST_ECHK;
      end
      // search for the public exponent
      ST_ECHK: begin
        if (status.n_zero) begin
          state_nxt = ST_FIN;
        end else if (status.e_lt_phi) begin
          op        = rsa_pkg::OP_GCD_INIT;
          state_nxt = ST_GCHK;
        end else begin
          state_nxt = ST_DINIT;
        end
      end
      ST_GCHK: begin
        if (status.ga_zero) begin
          if (status.gb_one) begin
            state_nxt = ST_DINIT;
          end else begin
            op        = rsa_pkg::OP_E_INC;
            state_nxt = ST_ECHK;
          end
        end else begin
          op        = rsa_pkg::OP_GCD_DIV;
          state_nxt = ST_GWAIT;
        end
      end
      ST_GWAIT: begin
        if (!status.div_busy) begin
          op        = rsa_pkg::OP_GCD_STEP;
          state_nxt = ST_GCHK;
        end
      end
      // private exponent by extended euclid
      ST_DINIT: begin
        if (status.phi_ge2) begin
          op        = rsa_pkg::OP_INV_INIT;
          state_nxt = ST_ICHK;
        end else begin
          state_nxt = ST_PINIT;
        end
      end
      ST_ICHK: begin
        if (status.inv_go) begin
          op        = rsa_pkg::OP_INV_DIV;
          state_nxt = ST_IDIV;
        end else begin
          op        = rsa_pkg::OP_D_SET;
          state_nxt = ST_PINIT;
        end
      end
      ST_IDIV: begin
        if (!status.div_busy) begin
          op        = rsa_pkg::OP_INV_MUL;
          state_nxt = ST_IMUL;
        end
      end
      ST_IMUL: begin
        if (!status.mm_busy) begin
          op        = rsa_pkg::OP_INV_UPD;
          state_nxt = ST_ICHK;
        end
      end
      // square and multiply, lsb first
      ST_PINIT: begin
        op        = rsa_pkg::OP_POW_INIT;
        state_nxt = ST_PBASE;
      end
      ST_PBASE: begin
        if (!status.div_busy) begin
          op        = rsa_pkg::OP_POW_BASE;
          state_nxt = ST_PCHK;
        end
      end
      ST_PCHK: begin
        if (status.ex_zero) begin
          state_nxt = ST_FIN;
        end else if (status.ex_lsb) begin
          op        = rsa_pkg::OP_POW_MACC;
          state_nxt = ST_PACC;
        end else begin
          op        = rsa_pkg::OP_POW_SQ;
          state_nxt = ST_PSQ;
        end
      end
      ST_PACC: begin
        if (!status.mm_busy) begin
          op        = rsa_pkg::OP_POW_WACC;
          state_nxt = ST_PSQS;
        end
      end
      ST_PSQS: begin
        op        = rsa_pkg::OP_POW_SQ;
        state_nxt = ST_PSQ;
      end
      ST_PSQ: begin
        if (!status.mm_busy) begin
          op        = rsa_pkg::OP_POW_WSQ;
          state_nxt = ST_PCHK;
        end
      end
      ST_FIN: begin
        op        = rsa_pkg::OP_FINISH;
        state_nxt = ST_DONE;
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_DONE);

endmodule

/* tb/rsa_crypt_checker.sv */
// checker for the rsa crypt core: tracks the prime registers, predicts each result
// and compares it with the result strobe; depends on rsa_pkg
`timescale 1ns / 1ps

module rsa_crypt_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rsa_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [rsa_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          in_req_type,
  input  logic [rsa_pkg::MSG_W-1:0]     in_message,
  input  logic                          out_valid,
  input  logic [rsa_pkg::MSG_W-1:0]     out_result,
  output int                            errors,
  output int                            pending
);

  localparam int MSG_W = rsa_pkg::MSG_W;

  logic [63:0] prime_a, prime_b;
  logic [MSG_W-1:0] exp_mem[16];
  logic [3:0] wr_ptr, rd_ptr;
  int fill;
  logic take_item, take_result;

  // exact modular product at double width
  function automatic logic [63:0] prod_mod(input logic [63:0] a, b, m);
    logic [127:0] t;
    t = 128'(a) * 128'(b);
    return 64'(t % 128'(m));
  endfunction

  function automatic logic [63:0] gcd64(input logic [63:0] a, b);
    logic [63:0] t;
    while (a != 0) begin
      t = b % a;
      b = a;
      a = t;
    end
    return b;
  endfunction

  // extended euclid, coefficients kept mod m; stops early when no inverse
  function automatic logic [63:0] inv_mod(input logic [63:0] a, m);
    logic [63:0] r0, r1, x, y, quo, rem, pr, ny;
    r0 = a; r1 = m; x = 64'(1) % m; y = '0;
    while (r0 > 1 && r1 != 0) begin
      quo = r0 / r1;
      rem = r0 % r1;
      pr  = prod_mod(quo, y, m);
      ny  = (x >= pr) ? x - pr : x + (m - pr);
      r0 = r1; r1 = rem; x = y; y = ny;
    end
    return x;
  endfunction

  // right to left square and multiply, product starts at 1
  function automatic logic [63:0] exp_mod(input logic [63:0] base, ex, m);
    logic [63:0] acc;
    acc = 64'(1);
    base = base % m;
    while (ex != 0) begin
      if (ex[0]) acc = prod_mod(acc, base, m);
      base = prod_mod(base, base, m);
      ex = ex >> 1;
    end
    return acc;
  endfunction

  function automatic logic [MSG_W-1:0] crypt_result(input logic kind,
                                                    input logic [MSG_W-1:0] msg);
    logic [63:0] n, pm1, qm1, phi, e, d, ex;
    n   = prime_a * prime_b;
    pm1 = (prime_a != 0) ? prime_a - 1 : '0;
    qm1 = (prime_b != 0) ? prime_b - 1 : '0;
    phi = pm1 * qm1;
    e = 64'(2);
    d = '0;
    while (e < phi) begin
      if (gcd64(e, phi) == 1) break;
      e++;
    end
    if (phi >= 2) d = inv_mod(e, phi) % phi;
    ex = (kind == rsa_pkg::REQ_ENCRYPT) ? e : d;
    if (n == 0) return '0;
    return MSG_W'(exp_mod(64'(msg), ex, n));
  endfunction

  assign take_item   = start && !busy;
  assign take_result = out_valid && (fill != 0);
  assign pending     = fill;

  // watch config, items and result strobes
  always @(posedge clk) begin
    if (!rst_n) begin
      prime_a <= 64'(rsa_pkg::P_RESET);
      prime_b <= 64'(rsa_pkg::Q_RESET);
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      fill    <= 0;
      errors  <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == rsa_pkg::REG_PRIME_P) prime_a <= 64'(cfg_wdata);
        else if (cfg_idx == rsa_pkg::REG_PRIME_Q) prime_b <= 64'(cfg_wdata);
      end
      if (take_item) begin
        exp_mem[wr_ptr] <= crypt_result(in_req_type, in_message);
        wr_ptr <= wr_ptr + 1'b1;
      end
      fill <= fill + int'(take_item) - int'(take_result);
      if (out_valid) begin
        if (fill == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d", $time, out_result);
          errors <= errors + 1;
        end else begin
          if (out_result !== exp_mem[rd_ptr]) begin
            $display("%0t: result mismatch, expected %0d, actual %0d",
                     $time, exp_mem[rd_ptr], out_result);
            errors <= errors + 1;
          end
          rd_ptr <= rd_ptr + 1'b1;
        end
      end
    end
  end

endmodule

/* tb/tb_top.sv */
// top of the rsa crypt core testbench: clock, reset, config writes and items
// depends on rsa_pkg, rsa_textbook_crypt_core and rsa_crypt_checker
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int MSG_W       = rsa_pkg::MSG_W;
  localparam int CFG_W       = rsa_pkg::CFG_W;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [rsa_pkg::CFG_IDX_W-1:0] cfg_idx = rsa_pkg::REG_PRIME_P;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic start = 0;
  logic busy;
  logic in_req_type = rsa_pkg::REQ_ENCRYPT;
  logic [MSG_W-1:0] in_message = '0;
  logic out_valid;
  logic [MSG_W-1:0] out_result;
  int errors, pending;
  int cycles = 0;

  int prime_pool[12] = '{3, 5, 7, 11, 13, 53, 61, 251, 257, 65521, 65537, 1000003};

  always #2 clk = ~clk;

  rsa_textbook_crypt_core dut (.*);

  rsa_crypt_checker chk (.*);

  // run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // wait until every expected result is back, plus some slack
  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_primes(input int p, input int q);
    drain();
    cfg_we = 1; cfg_idx = rsa_pkg::REG_PRIME_P; cfg_wdata = CFG_W'(p);
    @(negedge clk);
    cfg_idx = rsa_pkg::REG_PRIME_Q; cfg_wdata = CFG_W'(q);
    @(negedge clk);
    cfg_we = 0;
  endtask

  // send one item, with a random idle gap first
  task automatic send_item(input logic kind, input logic [MSG_W-1:0] msg, input int idle_pct);
    logic taken;
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    start = 1; in_req_type = kind; in_message = msg;
    taken = 0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
    end
    @(negedge clk);
    start = 0;
  endtask

  function automatic logic [MSG_W-1:0] rand_message(input int n);
    case ($urandom_range(3))
      0: return MSG_W'($urandom_range(n));
      1: return MSG_W'({$urandom, $urandom});
      2: return {MSG_W{1'b1}};
      default: return MSG_W'($urandom);
    endcase
  endfunction

  task automatic random_phase(input int items, input int idle_pct);
    int p, q;
    p = prime_pool[$urandom_range(11)];
    q = prime_pool[$urandom_range(11)];
    // keep the slow large-key runs rare
    if (p > 100000 && q > 100000) q = prime_pool[$urandom_range(8)];
    write_primes(p, q);
    for (int i = 0; i < items; i++)
      send_item(1'($urandom_range(1)), rand_message(p * q), idle_pct);
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n = 1;

    // reset primes: edges of the message range and reduction above n
    send_item(rsa_pkg::REQ_ENCRYPT, '0, 0);
    send_item(rsa_pkg::REQ_DECRYPT, '0, 0);
    send_item(rsa_pkg::REQ_ENCRYPT, MSG_W'(1), 0);
    send_item(rsa_pkg::REQ_DECRYPT, MSG_W'(3232), 0);
    send_item(rsa_pkg::REQ_ENCRYPT, MSG_W'(3233), 0);
    send_item(rsa_pkg::REQ_DECRYPT, MSG_W'(3300), 0);
    send_item(rsa_pkg::REQ_ENCRYPT, {MSG_W{1'b1}}, 0);
    send_item(rsa_pkg::REQ_DECRYPT, {MSG_W{1'b1}}, 0);

    // largest primes
    write_primes(2147483647, 2147483647);
    send_item(rsa_pkg::REQ_ENCRYPT, {MSG_W{1'b1}}, 0);
    send_item(rsa_pkg::REQ_DECRYPT, MSG_W'(62'h2aaa_aaaa_aaaa_aaaa), 0);

    // zero modulus, zero phi
    write_primes(0, 1);
    send_item(rsa_pkg::REQ_ENCRYPT, MSG_W'(5), 0);
    send_item(rsa_pkg::REQ_DECRYPT, MSG_W'(5), 0);
    // modulus one: zero exponent still gives one
    write_primes(1, 1);
    send_item(rsa_pkg::REQ_ENCRYPT, MSG_W'(7), 0);
    send_item(rsa_pkg::REQ_DECRYPT, MSG_W'(7), 0);
    // phi of one
    write_primes(2, 2);
    send_item(rsa_pkg::REQ_ENCRYPT, MSG_W'(3), 0);
    send_item(rsa_pkg::REQ_DECRYPT, MSG_W'(3), 0);
    // phi of two, no inverse
    write_primes(2, 3);
    send_item(rsa_pkg::REQ_ENCRYPT, MSG_W'(5), 0);
    send_item(rsa_pkg::REQ_DECRYPT, MSG_W'(5), 0);
    // small odd primes
    write_primes(3, 5);
    send_item(rsa_pkg::REQ_ENCRYPT, MSG_W'(14), 0);
    send_item(rsa_pkg::REQ_DECRYPT, MSG_W'(14), 0);

    // random phases at varied sender idling
    random_phase(12, 0);
    random_phase(12, 63);
    random_phase(12, 24);
    random_phase(12, 0);
    random_phase(12, 63);
    random_phase(12, 24);
    random_phase(10, 0);

    drain();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
